### rtl/rhcc_pkg.sv
package rhcc_pkg;

	// Field widths.
	localparam int CH_W   = 8;
	localparam int HUE_W  = 13;
	localparam int SAT_W  = 8;
	localparam int GRP_W  = 4;

	// Hue numerator is N = 960*diff + base*delta, below 5760*256.
	localparam int HNUM_W = 21;
	// Saturation dividend is delta*255.
	localparam int SNUM_W = 16;
	// Scaled values used by the class tests (100*255 fits).
	localparam int SCL_W  = 16;

	// One restoring step per hue quotient bit.
	localparam int DIV_STAGES = HUE_W;

	// Hue sector weights in sixteenths of a degree per unit of delta.
	localparam int HUE_STEP       = 960;
	localparam int HUE_GREEN_BASE = 1920;
	localparam int HUE_BLUE_BASE  = 3840;
	localparam int HUE_WRAP       = 5760;
	localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(HUE_WRAP);

	// Class thresholds on value and saturation, scaled by 100.
	localparam int PCT         = 100;
	localparam int VAL_DARK    = 4590;
	localparam int SAT_GRAY    = 16;
	localparam int VAL_WHITE   = 19890;
	localparam int SAT_BROWN   = 55;
	localparam int VAL_BROWN   = 15810;
	// Largest brightness that still counts as black.
	localparam logic [CH_W-1:0] DARK_MAX = CH_W'((VAL_DARK - 1) / PCT);

	// Hue band edges in sixteenths of a degree.
	localparam logic [HUE_W-1:0] H_BROWN_LO = HUE_W'(20 * 16);
	localparam logic [HUE_W-1:0] H_BROWN_HI = HUE_W'(50 * 16);
	localparam logic [HUE_W-1:0] H_RED_LO   = HUE_W'(15 * 16);
	localparam logic [HUE_W-1:0] H_RED_HI   = HUE_W'(345 * 16);
	localparam logic [HUE_W-1:0] H_ORANGE   = HUE_W'(42 * 16);
	localparam logic [HUE_W-1:0] H_YELLOW   = HUE_W'(68 * 16);
	localparam logic [HUE_W-1:0] H_LIME     = HUE_W'(92 * 16);
	localparam logic [HUE_W-1:0] H_GREEN    = HUE_W'(155 * 16);
	localparam logic [HUE_W-1:0] H_CYAN     = HUE_W'(195 * 16);
	localparam logic [HUE_W-1:0] H_BLUE     = HUE_W'(250 * 16);
	localparam logic [HUE_W-1:0] H_PURPLE   = HUE_W'(292 * 16);

	// Color class codes.
	typedef enum logic [GRP_W-1:0] {
		GRP_BLACK  = 4'd0,
		GRP_WHITE  = 4'd1,
		GRP_GRAY   = 4'd2,
		GRP_BROWN  = 4'd3,
		GRP_RED    = 4'd4,
		GRP_ORANGE = 4'd5,
		GRP_YELLOW = 4'd6,
		GRP_LIME   = 4'd7,
		GRP_GREEN  = 4'd8,
		GRP_CYAN   = 4'd9,
		GRP_BLUE   = 4'd10,
		GRP_PURPLE = 4'd11,
		GRP_PINK   = 4'd12
	} group_t;

	// Channel that holds the maximum.
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Class decisions that do not need the hue.
	typedef struct packed {
		logic dark;
		logic low_sat;
		logic bright;
		logic brown_sv;
		logic grey;
		logic mx_zero;
	} class_flags_t;

	// Front end result handed to the dividers.
	typedef struct packed {
		logic [HNUM_W-1:0] num;
		logic [CH_W-1:0]   dl;
		logic [SNUM_W-1:0] sdividend;
		logic [CH_W-1:0]   mx;
		class_flags_t      flags;
	} front_t;

	// State of both dividers in one stage.
	typedef struct packed {
		logic [HNUM_W-1:0] hrem;
		logic [CH_W-1:0]   hdiv;
		logic [HUE_W-1:0]  hq;
		logic [SNUM_W-1:0] srem;
		logic [CH_W-1:0]   sdiv;
		logic [SAT_W-1:0]  sq;
		logic [CH_W-1:0]   mx;
		class_flags_t      flags;
	} div_t;

endpackage

### rtl/rhcc_front.sv
module rhcc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic                      in_valid,
	input  logic [rhcc_pkg::CH_W-1:0] red,
	input  logic [rhcc_pkg::CH_W-1:0] green,
	input  logic [rhcc_pkg::CH_W-1:0] blue,
	output logic                      fr_valid,
	output rhcc_pkg::front_t          fr
);
	import rhcc_pkg::*;

	logic [CH_W-1:0] mx_c;
	logic [CH_W-1:0] mn_c;
	logic [CH_W-1:0] mag_c;
	sector_t         sec_c;
	logic            neg_c;

	logic            vld_s1;
	logic [CH_W-1:0] mx_s1;
	logic [CH_W-1:0] dl_s1;
	logic [CH_W-1:0] mag_s1;
	sector_t         sec_s1;
	logic            neg_s1;

	logic [HNUM_W-1:0] base_c;
	logic [HNUM_W-1:0] ofs_c;
	logic [SCL_W-1:0]  mx100_c;
	logic [SCL_W-1:0]  dl100_c;
	front_t            fr_c;

	logic   vld_s2;
	front_t fr_s2;

	// Find max and min; ties give the sector to red, then green.
	always_comb begin
		mx_c = red;
		if (green > mx_c) mx_c = green;
		if (blue > mx_c) mx_c = blue;
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
		if (mx_c == red) begin
			sec_c = SEC_RED;
			neg_c = green < blue;
			mag_c = neg_c ? blue - green : green - blue;
		end else if (mx_c == green) begin
			sec_c = SEC_GREEN;
			neg_c = blue < red;
			mag_c = neg_c ? red - blue : blue - red;
		end else begin
			sec_c = SEC_BLUE;
			neg_c = red < green;
			mag_c = neg_c ? green - red : red - green;
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			mx_s1  <= mx_c;
			dl_s1  <= mx_c - mn_c;
			mag_s1 <= mag_c;
			sec_s1 <= sec_c;
			neg_s1 <= neg_c;
		end
	end

	// Hue numerator, saturation dividend and the hue-free class tests.
	always_comb begin
		unique case (sec_s1)
			SEC_RED:   base_c = neg_s1 ? HNUM_W'(dl_s1) * HNUM_W'(HUE_WRAP) : '0;
			SEC_GREEN: base_c = HNUM_W'(dl_s1) * HNUM_W'(HUE_GREEN_BASE);
			SEC_BLUE:  base_c = HNUM_W'(dl_s1) * HNUM_W'(HUE_BLUE_BASE);
			default:   base_c = '0;
		endcase
		ofs_c   = HNUM_W'(mag_s1) * HNUM_W'(HUE_STEP);
		mx100_c = SCL_W'(mx_s1) * SCL_W'(PCT);
		dl100_c = SCL_W'(dl_s1) * SCL_W'(PCT);

		fr_c.num       = neg_s1 ? base_c - ofs_c : base_c + ofs_c;
		fr_c.dl        = dl_s1;
		fr_c.sdividend = (SNUM_W'(dl_s1) << CH_W) - SNUM_W'(dl_s1);
		fr_c.mx        = mx_s1;

		fr_c.flags.dark     = mx100_c < SCL_W'(VAL_DARK);
		fr_c.flags.low_sat  = dl100_c < SCL_W'(mx_s1) * SCL_W'(SAT_GRAY);
		fr_c.flags.bright   = mx100_c > SCL_W'(VAL_WHITE);
		fr_c.flags.brown_sv = (dl100_c < SCL_W'(mx_s1) * SCL_W'(SAT_BROWN))
			&& (mx100_c < SCL_W'(VAL_BROWN));
		fr_c.flags.grey     = dl_s1 == '0;
		fr_c.flags.mx_zero  = mx_s1 == '0;
	end

	// Stage 2 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			fr_s2 <= fr_c;
		end
	end

	assign fr_valid = vld_s2;
	assign fr       = fr_s2;

endmodule

### rtl/rhcc_divider.sv
module rhcc_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             fr_valid,
	input  rhcc_pkg::front_t fr,
	output logic             dv_valid,
	output rhcc_pkg::div_t   dv
);
	import rhcc_pkg::*;

	div_t prev [DIV_STAGES];
	div_t nxt  [DIV_STAGES];
	div_t div_s [DIV_STAGES];
	logic div_vld_s [DIV_STAGES];

	// The first step starts from the front end result.
	always_comb begin
		prev[0].hrem  = fr.num;
		prev[0].hdiv  = fr.dl;
		prev[0].hq    = '0;
		prev[0].srem  = fr.sdividend;
		prev[0].sdiv  = fr.mx;
		prev[0].sq    = '0;
		prev[0].mx    = fr.mx;
		prev[0].flags = fr.flags;
	end

	// Each stage settles one hue quotient bit, and one saturation bit in the low stages.
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		localparam int K = DIV_STAGES - 1 - j;

		logic [HNUM_W-1:0] hsh;
		logic [SNUM_W-1:0] nsrem;
		logic [SAT_W-1:0]  nsq;

		if (j > 0) begin : g_link
			assign prev[j] = div_s[j-1];
		end

		if (K < SAT_W) begin : g_sat
			logic [SNUM_W-1:0] ssh;
			assign ssh = SNUM_W'(prev[j].sdiv) << K;
			always_comb begin
				nsrem = prev[j].srem;
				nsq   = prev[j].sq;
				if (prev[j].srem >= ssh) begin
					nsrem  = prev[j].srem - ssh;
					nsq[K] = 1'b1;
				end
			end
		end else begin : g_nosat
			assign nsrem = prev[j].srem;
			assign nsq   = prev[j].sq;
		end

		assign hsh = HNUM_W'(prev[j].hdiv) << K;

		// Restoring step on the hue numerator.
		always_comb begin
			nxt[j]      = prev[j];
			nxt[j].srem = nsrem;
			nxt[j].sq   = nsq;
			if (prev[j].hrem >= hsh) begin
				nxt[j].hrem  = prev[j].hrem - hsh;
				nxt[j].hq[K] = 1'b1;
			end
		end

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[j] <= 1'b0;
			end else if (advance) begin
				div_vld_s[j] <= (j == 0) ? fr_valid : div_vld_s[(j > 0) ? j - 1 : 0];
			end
		end

		// Payload of this stage.
		always_ff @(posedge clk) begin
			if (advance) begin
				div_s[j] <= nxt[j];
			end
		end
	end

	assign dv_valid = div_vld_s[DIV_STAGES-1];
	assign dv       = div_s[DIV_STAGES-1];

	// A colored pixel yields a hue below one full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv.flags.grey |-> dv.hq < HUE_FULL)
		else $error("hue quotient out of range");

	// The hue division leaves a remainder below the divisor.
	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv.flags.grey |-> dv.hrem < HNUM_W'(dv.hdiv))
		else $error("hue remainder not below delta");

	// The saturation division leaves a remainder below the divisor.
	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv.flags.mx_zero |-> dv.srem < SNUM_W'(dv.sdiv))
		else $error("saturation remainder not below max");

	// A held pipeline keeps its last valid bit.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> dv_valid == $past(dv_valid))
		else $error("divider valid moved while held");

endmodule

### rtl/rhcc_class.sv
module rhcc_class (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       dv_valid,
	input  rhcc_pkg::div_t             dv,
	output logic                       out_valid,
	output logic [rhcc_pkg::HUE_W-1:0] hue_sixteenths,
	output logic [rhcc_pkg::SAT_W-1:0] saturation,
	output logic [rhcc_pkg::CH_W-1:0]  brightness,
	output logic [rhcc_pkg::GRP_W-1:0] color_group
);
	import rhcc_pkg::*;

	logic [HUE_W-1:0] hue_c;
	logic [SAT_W-1:0] sat_c;
	group_t           grp_c;

	logic             out_valid_q;
	logic [HUE_W-1:0] hue_q;
	logic [SAT_W-1:0] sat_q;
	logic [CH_W-1:0]  bri_q;
	group_t           grp_q;

	// Grey pixels have no hue; pixels with a zero maximum have no saturation.
	assign hue_c = dv.flags.grey ? '0 : dv.hq;
	assign sat_c = dv.flags.mx_zero ? '0 : dv.sq;

	// Class decision: value and saturation first, then the hue bands.
	always_comb begin
		priority if (dv.flags.dark) begin
			grp_c = GRP_BLACK;
		end else if (dv.flags.low_sat) begin
			grp_c = dv.flags.bright ? GRP_WHITE : GRP_GRAY;
		end else if (dv.flags.brown_sv && hue_c >= H_BROWN_LO && hue_c < H_BROWN_HI) begin
			grp_c = GRP_BROWN;
		end else if (hue_c < H_RED_LO || hue_c >= H_RED_HI) begin
			grp_c = GRP_RED;
		end else if (hue_c < H_ORANGE) begin
			grp_c = GRP_ORANGE;
		end else if (hue_c < H_YELLOW) begin
			grp_c = GRP_YELLOW;
		end else if (hue_c < H_LIME) begin
			grp_c = GRP_LIME;
		end else if (hue_c < H_GREEN) begin
			grp_c = GRP_GREEN;
		end else if (hue_c < H_CYAN) begin
			grp_c = GRP_CYAN;
		end else if (hue_c < H_BLUE) begin
			grp_c = GRP_BLUE;
		end else if (hue_c < H_PURPLE) begin
			grp_c = GRP_PURPLE;
		end else begin
			grp_c = GRP_PINK;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= dv_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			hue_q <= hue_c;
			sat_q <= sat_c;
			bri_q <= dv.mx;
			grp_q <= grp_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign hue_sixteenths = hue_q;
	assign saturation     = sat_q;
	assign brightness     = bri_q;
	assign color_group    = grp_q;

	// Black is only ever reported for a dark pixel.
	a_black_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grp_q == GRP_BLACK |-> bri_q <= DARK_MAX)
		else $error("black class on a bright pixel");

endmodule

### rtl/rgb_to_hsv_color_classifier.sv
// RGB to HSV converter with color classifier.
// Input channel: in_valid / in_stall carry one pixel (red, green, blue) per
// transfer. Output channel: out_valid / out_stall carry hue_sixteenths,
// saturation, brightness and color_group for each pixel, in input order.
// Throughput is one pixel per clock while the output is taken.
// The path from input transfer to out_valid passes two front-end
// stages (max/min, then hue numerator and class tests), thirteen restoring
// divider stages that produce one hue quotient bit each (saturation bits
// ride in the last eight), and the output register.
// When out_valid is high and out_stall is asserted, the whole pipeline
// holds and in_stall is raised in the same cycle; nothing is dropped or
// repeated, and transfers resume as soon as out_stall falls.
// Reset (arst_n low) clears all valid bits at once; the block can take a
// pixel as soon as reset is released.
module rgb_to_hsv_color_classifier (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rhcc_pkg::CH_W-1:0]  red,
	input  logic [rhcc_pkg::CH_W-1:0]  green,
	input  logic [rhcc_pkg::CH_W-1:0]  blue,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rhcc_pkg::HUE_W-1:0] hue_sixteenths,
	output logic [rhcc_pkg::SAT_W-1:0] saturation,
	output logic [rhcc_pkg::CH_W-1:0]  brightness,
	output logic [rhcc_pkg::GRP_W-1:0] color_group
);
	import rhcc_pkg::*;

	logic   advance;
	logic   fr_valid;
	front_t fr;
	logic   dv_valid;
	div_t   dv;

	// The pipeline moves unless a result waits on a stalled output.
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// Max, min, hue numerator and class tests.
	rhcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (in_valid),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.fr_valid (fr_valid),
		.fr       (fr)
	);

	// Hue and saturation division.
	rhcc_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.fr_valid (fr_valid),
		.fr       (fr),
		.dv_valid (dv_valid),
		.dv       (dv)
	);

	// Final classification and output register.
	rhcc_class u_class (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.dv_valid       (dv_valid),
		.dv             (dv),
		.out_valid      (out_valid),
		.hue_sixteenths (hue_sixteenths),
		.saturation     (saturation),
		.brightness     (brightness),
		.color_group    (color_group)
	);

endmodule
